// ===== sv/dq_pkg.sv =====
package dq_pkg;

    // Number of word cells in the chain.
    localparam int DEPTH = 16;

    // Width of the entry count, wide enough to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0]         count_t;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    // Operation broadcast to every cell in the same cycle. At most one of the
    // four strobes is set, and only for a legal, accepted transaction.
    typedef struct packed {
        logic  add_front;
        logic  add_back;
        logic  take_front;
        logic  take_back;
        word_t value;
    } cell_op_t;

endpackage

// ===== sv/double_ended_queue_core.sv =====
// A command transaction accepted at a clock edge has its result
// transaction on the response port right after that edge.
// Throughput: one command per cycle while the response side does not stall;
// a single response register holds the result, so a stalled response stalls
// the command port. Reset (rst_n low, asynchronous) empties the queue and
// drops any pending response; stored words themselves are not cleared.
module double_ended_queue_core (
    input  logic                         clk,
    input  logic                         rst_n,
    // Command channel.
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic [1:0]                   cmd,
    input  logic signed [31:0]           value,
    // Response channel.
    output logic                         rsp_valid,
    input  logic                         rsp_stall,
    output logic [1:0]                   status,
    output logic signed [31:0]           popped_value,
    output logic [dq_pkg::CNT_W-1:0]     entry_count,
    output logic signed [31:0]           front_value,
    output logic signed [31:0]           back_value
);

    // The queue is a row of cells. Cell 0 always holds the front word and
    // the occupied cells form a contiguous run starting at cell 0, so the
    // valid bits are a thermometer code of the occupancy. Push front shifts
    // the whole row one cell toward the back; pop front shifts it toward the
    // front. Push back and pop back touch only the cell at the edge of the
    // occupied run, which each cell detects from its neighbors.

    dq_pkg::word_t            cell_data_q [dq_pkg::DEPTH];
    dq_pkg::word_t            cell_data_d [dq_pkg::DEPTH];
    logic [dq_pkg::DEPTH-1:0] cell_valid_q;
    logic [dq_pkg::DEPTH-1:0] cell_valid_d;
    logic [dq_pkg::DEPTH-1:0] back_edge_q;
    logic [dq_pkg::DEPTH-1:0] back_edge_d;

    dq_pkg::cell_op_t op;
    dq_pkg::cmd_t     cmd_e;
    dq_pkg::status_t  status_c;
    dq_pkg::word_t    popped_c;
    dq_pkg::word_t    back_cur;
    dq_pkg::word_t    back_new;
    dq_pkg::word_t    front_new;
    dq_pkg::count_t   count_reg;
    dq_pkg::count_t   count_next;

    logic             accept;
    logic             is_full;
    logic             is_empty;

    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    dq_pkg::status_t  status_reg;
    dq_pkg::word_t    popped_reg;
    dq_pkg::count_t   count_out_reg;
    dq_pkg::word_t    front_reg;
    dq_pkg::word_t    back_reg;

    // A new command is taken unless the response register is full and held.
    assign cmd_stall = rsp_valid_reg && rsp_stall;
    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_e     = dq_pkg::cmd_t'(cmd);

    assign is_full  = cell_valid_q[dq_pkg::DEPTH-1];
    assign is_empty = !cell_valid_q[0];

    for (genvar i = 0; i < dq_pkg::DEPTH; i++)
    begin : g_cell
        dq_pkg::word_t left_data;
        dq_pkg::word_t right_data;
        logic          left_valid;
        logic          right_valid;

        // The front cell sees the incoming word as its left neighbor; the
        // last cell sees an empty slot on its right.
        if (i == 0)
        begin : g_first
            assign left_data  = op.value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_data  = cell_data_q[i-1];
            assign left_valid = cell_valid_q[i-1];
        end

        if (i == dq_pkg::DEPTH - 1)
        begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_data  = cell_data_q[i+1];
            assign right_valid = cell_valid_q[i+1];
        end

        dq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data_q      (cell_data_q[i]),
            .valid_q     (cell_valid_q[i]),
            .data_d      (cell_data_d[i]),
            .valid_d     (cell_valid_d[i])
        );
    end

    // A cell is the back of the run when it is occupied and the next cell
    // is not; the last cell has no next cell.
    assign back_edge_q = cell_valid_q & ~{1'b0, cell_valid_q[dq_pkg::DEPTH-1:1]};
    assign back_edge_d = cell_valid_d & ~{1'b0, cell_valid_d[dq_pkg::DEPTH-1:1]};

    // Back word selection: exactly one cell is the edge of the occupied run
    // (or none when empty), so an AND-OR over the row picks it out.
    always_comb
    begin
        back_cur = '0;
        back_new = '0;
        for (int i = 0; i < dq_pkg::DEPTH; i++)
        begin
            if (back_edge_q[i])
            begin
                back_cur = back_cur | cell_data_q[i];
            end
            if (back_edge_d[i])
            begin
                back_new = back_new | cell_data_d[i];
            end
        end
    end

    assign front_new = cell_valid_d[0] ? cell_data_d[0] : '0;

    // Command decode. Strobes reach the cells only for an accepted command
    // that does not overflow or underflow.
    always_comb
    begin
        op            = '0;
        op.value      = value;
        status_c      = dq_pkg::ST_DONE;
        popped_c      = '0;
        count_next    = count_reg;
        unique case (cmd_e)
            dq_pkg::CMD_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    status_c = dq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    op.add_front = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            dq_pkg::CMD_PUSH_BACK:
            begin
                if (is_full)
                begin
                    status_c = dq_pkg::ST_OVERFLOW;
                end
                else
                begin
                    op.add_back = accept;
                    count_next  = count_reg + 1'b1;
                end
            end
            dq_pkg::CMD_POP_FRONT:
            begin
                if (is_empty)
                begin
                    status_c = dq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    op.take_front = accept;
                    popped_c      = cell_data_q[0];
                    count_next    = count_reg - 1'b1;
                end
            end
            dq_pkg::CMD_POP_BACK:
            begin
                if (is_empty)
                begin
                    status_c = dq_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    op.take_back = accept;
                    popped_c     = back_cur;
                    count_next   = count_reg - 1'b1;
                end
            end
            default:
            begin
                status_c = dq_pkg::ST_DONE;
            end
        endcase
    end

    // The response register empties when its transaction is taken and fills
    // on every accepted command.
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        if (accept)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg    <= status_c;
            popped_reg    <= popped_c;
            count_out_reg <= count_next;
            front_reg     <= front_new;
            back_reg      <= back_new;
        end
    end

    assign rsp_valid    = rsp_valid_reg;
    assign status       = status_reg;
    assign popped_value = popped_reg;
    assign entry_count  = count_out_reg;
    assign front_value  = front_reg;
    assign back_value   = back_reg;

endmodule

// ===== sv/dq_cell.sv =====
module dq_cell (
    input  logic             clk,
    input  logic             rst_n,
    input  dq_pkg::cell_op_t op,
    input  dq_pkg::word_t    left_data,
    input  logic             left_valid,
    input  dq_pkg::word_t    right_data,
    input  logic             right_valid,
    output dq_pkg::word_t    data_q,
    output logic             valid_q,
    output dq_pkg::word_t    data_d,
    output logic             valid_d
);

    dq_pkg::word_t data_reg;
    dq_pkg::word_t data_next;
    logic          valid_reg;
    logic          valid_next;

    // The cell is the back of the queue when it holds a word and its right
    // neighbor does not; it is the first free slot when it is empty and its left neighbor holds a word.
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        if (op.add_front)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (op.take_front)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (op.add_back && !valid_reg && left_valid)
        begin
            data_next  = op.value;
            valid_next = 1'b1;
        end
        else if (op.take_back && valid_reg && !right_valid)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data_q  = data_reg;
    assign valid_q = valid_reg;
    assign data_d  = data_next;
    assign valid_d = valid_next;

endmodule

// ===== sv/dq_checker.sv =====
module dq_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     rsp_valid,
    input logic                     rsp_stall,
    input logic [1:0]               status,
    input logic signed [31:0]       popped_value,
    input logic [dq_pkg::CNT_W-1:0] entry_count,
    input logic signed [31:0]       front_value,
    input logic signed [31:0]       back_value
);

    localparam logic [dq_pkg::CNT_W-1:0] MaxCount = dq_pkg::CNT_W'(dq_pkg::DEPTH);

    // The count never exceeds the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> entry_count <= MaxCount)
        else $error("entry count above depth");

    // An empty queue shows zero at both ends.
    a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_count == '0 |-> front_value == '0 && back_value == '0)
        else $error("empty queue shows a nonzero end word");

    // With one word stored, front and back are the same word.
    a_single_word: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && entry_count == dq_pkg::CNT_W'(1) |-> front_value == back_value)
        else $error("single stored word differs at front and back");

    // A failed command pops nothing.
    a_fail_no_pop: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status != dq_pkg::ST_DONE |-> popped_value == '0)
        else $error("failed command reports a popped word");

    // A stalled response transaction holds.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status)
            && $stable(popped_value) && $stable(entry_count))
        else $error("stalled response changed");

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .status       (status),
    .popped_value (popped_value),
    .entry_count  (entry_count),
    .front_value  (front_value),
    .back_value   (back_value)
);

// ===== bench/double_ended_queue_checker.sv =====
module double_ended_queue_checker
    import dq_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                cmd_stall,
    input  logic [1:0]          cmd,
    input  logic signed [31:0]  value,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [1:0]          status,
    input  logic signed [31:0]  popped_value,
    input  logic [CNT_W-1:0]    entry_count,
    input  logic signed [31:0]  front_value,
    input  logic signed [31:0]  back_value,
    output int                  fail_count,
    output int                  pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        status_t status;
        word_t   popped;
        count_t  count;
        word_t   front;
        word_t   back;
    } deque_result_t;

    // Shadow copy of the queue contents and its circular indices.
    word_t         shadow_slots [DEPTH];
    int            head_idx;
    int            tail_idx;
    int            stored_words;
    deque_result_t expected_results [$];
    int            errors = 0;

    assign fail_count = errors;

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
        begin
            $display("%0t ns: %s", $time, msg);
        end
    endtask

    // Applies one command to the shadow queue and returns the result it must produce.
    function automatic deque_result_t apply_command(cmd_t op, word_t word);
        deque_result_t r;
        r.status = ST_DONE;
        r.popped = '0;
        r.front  = '0;
        r.back   = '0;
        case (op)
            CMD_PUSH_FRONT:
            begin
                if (stored_words == DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    head_idx = (head_idx == 0) ? DEPTH - 1 : head_idx - 1;
                    shadow_slots[head_idx] = word;
                    stored_words++;
                end
            end
            CMD_PUSH_BACK:
            begin
                if (stored_words == DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    shadow_slots[tail_idx] = word;
                    tail_idx = (tail_idx == DEPTH - 1) ? 0 : tail_idx + 1;
                    stored_words++;
                end
            end
            CMD_POP_FRONT:
            begin
                if (stored_words == 0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    r.popped = shadow_slots[head_idx];
                    head_idx = (head_idx == DEPTH - 1) ? 0 : head_idx + 1;
                    stored_words--;
                end
            end
            default:
            begin
                if (stored_words == 0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    tail_idx = (tail_idx == 0) ? DEPTH - 1 : tail_idx - 1;
                    r.popped = shadow_slots[tail_idx];
                    stored_words--;
                end
            end
        endcase
        if (stored_words != 0)
        begin
            r.front = shadow_slots[head_idx];
            r.back  = shadow_slots[(tail_idx == 0) ? DEPTH - 1 : tail_idx - 1];
        end
        r.count = count_t'(stored_words);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        deque_result_t want;
        if (!rst_n)
        begin
            head_idx     = 0;
            tail_idx     = 0;
            stored_words = 0;
            expected_results.delete();
            pending <= 0;
        end
        else
        begin
            // Responses are matched before the new command is queued.
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_results.size() == 0)
                begin
                    report_mismatch($sformatf("response with no command outstanding, status %0d",
                                              status));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status: expected %0d, got %0d",
                                                  want.status, status));
                    if (popped_value !== want.popped)
                        report_mismatch($sformatf("popped_value: expected %h, got %h",
                                                  want.popped, popped_value));
                    if (entry_count !== want.count)
                        report_mismatch($sformatf("entry_count: expected %0d, got %0d",
                                                  want.count, entry_count));
                    if (front_value !== want.front)
                        report_mismatch($sformatf("front_value: expected %h, got %h",
                                                  want.front, front_value));
                    if (back_value !== want.back)
                        report_mismatch($sformatf("back_value: expected %h, got %h",
                                                  want.back, back_value));
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                expected_results.insert(expected_results.size(),
                                        apply_command(cmd_t'(cmd), value));
            end
            pending <= expected_results.size();
        end
    end

endmodule

// ===== bench/double_ended_queue_core_tb.sv =====
module double_ended_queue_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dq_pkg::*;

    // Every input of the block starts at a known value.
    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic [1:0]         cmd       = CMD_PUSH_FRONT;
    logic signed [31:0] value     = '0;
    logic               rsp_stall = 1'b0;

    logic               cmd_stall;
    logic               rsp_valid;
    logic [1:0]         status;
    logic signed [31:0] popped_value;
    logic [CNT_W-1:0]   entry_count;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;

    int fail_count;
    int pending;

    // Percentages that set how often the command side idles and the response
    // side stalls. They change from one traffic phase to the next.
    int sender_idle_pct = 0;
    int rsp_stall_pct   = 0;

    always #4 clk = ~clk;

    double_ended_queue_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count),
        .front_value  (front_value),
        .back_value   (back_value)
    );

    double_ended_queue_checker checker_inst (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .value        (value),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .status       (status),
        .popped_value (popped_value),
        .entry_count  (entry_count),
        .front_value  (front_value),
        .back_value   (back_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // The response side stalls at random, one fresh decision per clock.
    always @(posedge clk)
    begin
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // Watchdog. Two milliseconds leaves a wide margin over the slowest
    // legitimate run.
    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offers one command transaction and returns at the edge where it is
    // accepted. Idle cycles may be inserted before the offer; once valid is
    // raised the payload holds steady until the block takes it.
    task automatic send_command(input cmd_t op, input word_t word);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= op;
        value     <= word;
        @(posedge clk);
        while (cmd_stall)
        begin
            @(posedge clk);
        end
    endtask

    // Stops offering commands and waits until every response has come back.
    // The outstanding count is updated after each edge, so an edge is let
    // pass before it is trusted.
    task automatic wait_drained();
        cmd_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random traffic in bursts. Each burst leans toward pushes, toward pops
    // or toward neither, so the queue keeps swinging between empty and full
    // and both overflow and underflow come up often. One word in eight is an
    // extreme value.
    task automatic run_random(input int count);
        int    left;
        int    burst;
        int    push_pct;
        cmd_t  op;
        word_t word;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(40, 6);
            case ($urandom_range(2))
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            repeat (burst)
            begin
                if (left > 0)
                begin
                    if ($urandom_range(99) < push_pct)
                        op = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
                    else
                        op = $urandom_range(1) ? CMD_POP_BACK : CMD_POP_FRONT;
                    if ($urandom_range(7) == 0)
                    begin
                        case ($urandom_range(3))
                            0:       word = 32'sh8000_0000;
                            1:       word = 32'sh7FFF_FFFF;
                            2:       word = -32'sd1;
                            default: word = '0;
                        endcase
                    end
                    else
                    begin
                        word = $urandom;
                    end
                    send_command(op, word);
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        // Reset is held and then released on a falling edge, away from the rising edge.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // Directed opening, no idling. Both pops on an empty queue underflow,
        // then the first push front wraps the head index below zero.
        send_command(CMD_POP_FRONT, 32'sh1234_5678);
        send_command(CMD_POP_BACK, -32'sd1);
        send_command(CMD_PUSH_FRONT, 32'sh7FFF_FFFF);
        send_command(CMD_PUSH_BACK, 32'sh8000_0000);
        send_command(CMD_PUSH_FRONT, -32'sd1);
        send_command(CMD_PUSH_BACK, '0);
        send_command(CMD_POP_BACK, '0);
        send_command(CMD_POP_FRONT, '0);
        // Fill to capacity from both ends with walking-one and walking-zero
        // words, then push once at each end into the full queue.
        for (int i = 0; i < 14; i++)
        begin
            if (i % 2 == 0)
                send_command(CMD_PUSH_FRONT, word_t'(32'h1 << (i * 2)));
            else
                send_command(CMD_PUSH_BACK, word_t'(~(32'h1 << (i * 2 + 1))));
        end
        send_command(CMD_PUSH_FRONT, 32'sh5555_5555);
        send_command(CMD_PUSH_BACK, 32'shAAAA_AAAA);
        wait_drained();

        // Four traffic phases: free running, sparse commands, a mostly
        // stalled response side, and light idling on both. Between phases the
        // command side pauses until every response has arrived.
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    sender_idle_pct = 0;
                    rsp_stall_pct   = 0;
                end
                1:
                begin
                    sender_idle_pct = 79;
                    rsp_stall_pct   = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    rsp_stall_pct   = 79;
                end
                default:
                begin
                    sender_idle_pct = 11;
                    rsp_stall_pct   = 11;
                end
            endcase
            run_random(250);
            wait_drained();
        end

        // The clock runs on with no stalls so that any stray response is still caught.
        rsp_stall_pct = 0;
        repeat (8) @(posedge clk);

        if (fail_count == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
